[rtl/cfvg_pkg.sv]
// cfvg_pkg: shared types, constants and the cordic arctangent table
// for the circle fan vertex generator; no dependencies
package cfvg_pkg;
   localparam int CORDIC_STEPS = 32;
   localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
   localparam logic [31:0] RADIUS_MAX = 32'h7FFF_FFFF;
   localparam logic [5:0] SEG_RESET = 6'd32;
   localparam logic [5:0] MAX_SEGMENTS = 6'd62;

   typedef struct packed {
      logic [31:0] radius;
      logic [5:0]  seg_count;
   } job_type;

   typedef enum logic [2:0] {
      BE_IDLE, BE_ANGLE, BE_CORDIC, BE_MUL, BE_OUT, BE_CENTRE
   } be_state_type;

   typedef enum logic [1:0] {
      FE_IDLE, FE_SQ, FE_ROOT, FE_PUSH
   } fe_state_type;

   function automatic logic [31:0] atan_turn(input logic [4:0] k);
      logic [31:0] r;
      begin
         case (k)
            5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
            5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
            5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
            5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
            5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
            5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
            5'd20: r = 32'd652;       5'd21: r = 32'd326;
            5'd22: r = 32'd163;       5'd23: r = 32'd81;
            5'd24: r = 32'd41;        5'd25: r = 32'd20;
            5'd26: r = 32'd10;        5'd27: r = 32'd5;
            5'd28: r = 32'd3;         5'd29: r = 32'd1;
            5'd30: r = 32'd1;         default: r = 32'd0;
         endcase
         return r;
      end
   endfunction
endpackage

[rtl/cfvg_if.sv]
// cfvg_if: valid/ready channel interfaces for requests, vertices and the csr
// depends on nothing
interface cfvg_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] center_x, center_y, center_z, edge_x, edge_y, edge_z;
   modport source(output valid, center_x, center_y, center_z, edge_x, edge_y, edge_z,
                  input ready);
   modport sink(input valid, center_x, center_y, center_z, edge_x, edge_y, edge_z,
                output ready);
endinterface

interface cfvg_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] vertex_x, vertex_y;
   logic [5:0]  vertex_number, tri_first, tri_second, tri_third;
   logic        tri_valid, last;
   modport source(output valid, vertex_x, vertex_y, vertex_number, tri_valid,
                  tri_first, tri_second, tri_third, last, input ready);
   modport sink(input valid, vertex_x, vertex_y, vertex_number, tri_valid,
                tri_first, tri_second, tri_third, last, output ready);
endinterface

interface cfvg_csr_if;
   logic       valid;
   logic       ready;
   logic [5:0] data;
   modport source(output valid, data, input ready);
   modport sink(input valid, data, output ready);
endinterface

[rtl/cfvg_front.sv]
// cfvg_front: accepts a request, squares the differences over cycles and
// takes the integer square root two bits a cycle; uses cfvg_pkg
module cfvg_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [31:0]          cx, cy, cz, ex, ey, ez,
   input  logic [5:0]           seg_count,
   output logic                 push,
   input  logic                 full,
   output cfvg_pkg::job_type    job
);
   cfvg_pkg::fe_state_type state_ff, state_in;
   logic [31:0] m_ff [3], m_in [3];
   logic        big_ff, big_in;
   logic [1:0]  sq_ff, sq_in;
   logic [65:0] sum_ff, sum_in;
   logic [64:0] res_ff, res_in;
   logic [4:0]  step_ff, step_in;
   logic [5:0]  seg_ff, seg_in;
   logic [32:0] d [3];
   logic [32:0] am [3];
   logic [63:0] sq;
   logic [64:0] trial;
   logic [65:0] bitv;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= cfvg_pkg::FE_IDLE;
      else state_ff <= state_in;
      m_ff <= m_in; big_ff <= big_in; sq_ff <= sq_in; sum_ff <= sum_in;
      res_ff <= res_in; step_ff <= step_in; seg_ff <= seg_in;
   end

   always_comb begin
      d[0] = {ex[31], ex} - {cx[31], cx};
      d[1] = {ey[31], ey} - {cy[31], cy};
      d[2] = {ez[31], ez} - {cz[31], cz};
      for (int j = 0; j < 3; j++) am[j] = d[j][32] ? -d[j] : d[j];
      sq = m_ff[sq_ff] * m_ff[sq_ff];
      bitv = 66'd1 << {step_ff, 1'b0};
      trial = res_ff + bitv[64:0];
   end

   always_comb begin
      state_in = state_ff; m_in = m_ff; big_in = big_ff; sq_in = sq_ff;
      sum_in = sum_ff; res_in = res_ff; step_in = step_ff; seg_in = seg_ff;
      req_ready = 1'b0; push = 1'b0;
      job.seg_count = seg_ff;
      job.radius = (big_ff || res_ff > 65'(cfvg_pkg::RADIUS_MAX)) ?
                   cfvg_pkg::RADIUS_MAX : res_ff[31:0];
      unique case (state_ff)
         cfvg_pkg::FE_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               big_in = 1'b0;
               for (int j = 0; j < 3; j++) begin
                  m_in[j] = am[j][31:0];
                  if (am[j] > 33'(cfvg_pkg::RADIUS_MAX)) big_in = 1'b1;
               end
               seg_in = (seg_count == 6'd0) ? 6'd1 :
                        (seg_count > cfvg_pkg::MAX_SEGMENTS) ? cfvg_pkg::MAX_SEGMENTS :
                        seg_count;
               sum_in = '0; sq_in = '0;
               state_in = cfvg_pkg::FE_SQ;
            end
         end
         cfvg_pkg::FE_SQ: begin
            sum_in = sum_ff + {2'b00, sq};
            if (sq_ff == 2'd2) begin
               res_in = '0;
               step_in = 5'd31;
               state_in = cfvg_pkg::FE_ROOT;
            end
            sq_in = sq_ff + 2'd1;
         end
         cfvg_pkg::FE_ROOT: begin
            // bit = 4^step, from 2^62 down to 1
            if ({1'b0, sum_ff} >= {2'b00, trial}) begin
               sum_in = sum_ff - {1'b0, trial};
               res_in = (res_ff >> 1) + bitv[64:0];
            end else begin
               res_in = res_ff >> 1;
            end
            step_in = step_ff - 5'd1;
            if (step_ff == 5'd0) state_in = cfvg_pkg::FE_PUSH;
         end
         cfvg_pkg::FE_PUSH: begin
            if (!full) begin
               push = 1'b1;
               state_in = cfvg_pkg::FE_IDLE;
            end
         end
         default: state_in = cfvg_pkg::FE_IDLE;
      endcase
   end
endmodule

[rtl/cfvg_queue.sv]
// cfvg_queue: two-entry job queue between the front and back parts
// uses cfvg_pkg
module cfvg_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cfvg_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output cfvg_pkg::job_type pop_job
);
   cfvg_pkg::job_type mem_ff [2];
   logic        wp_ff, rp_ff;
   logic [1:0]  cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wp_ff] <= push_job;
   end

   assign full = cnt_ff == 2'd2;
   assign empty = cnt_ff == 2'd0;
   assign pop_job = mem_ff[rp_ff];
endmodule

[rtl/cfvg_back.sv]
// cfvg_back: walks the rim vertices of a job (angle, cordic, scaling and
// the output register), then sends the centre vertex; uses cfvg_pkg
module cfvg_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              empty,
   input  cfvg_pkg::job_type job,
   output logic              pop,
   cfvg_rsp_if.source        rsp
);
   cfvg_pkg::be_state_type state_ff, state_in;
   logic [31:0] rad_ff, rad_in;
   logic [5:0]  n_ff, n_in, i_ff, i_in;
   logic [37:0] num_ff, num_in;
   logic [31:0] ang_ff, ang_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [32:0] z_ff, z_in;
   logic [4:0]  k_ff, k_in;
   logic        flip_ff, flip_in;
   logic signed [65:0] px_ff, px_in, py_ff, py_in;
   logic        ov_ff, ov_in;
   logic [31:0] ox_ff, ox_in, oy_ff, oy_in;
   logic [5:0]  onum_ff, onum_in, of_ff, of_in, os_ff, os_in, ot_ff, ot_in;
   logic        otv_ff, otv_in, olast_ff, olast_in;
   logic [39:0] diff;
   logic [31:0] at;
   logic signed [65:0] rx, ry;

   function automatic logic [31:0] sat(input logic signed [65:0] p);
      logic signed [65:0] q;
      begin
         q = (p + 66'sd536870912) >>> 30;
         if (q > 66'sd2147483647) return 32'h7FFF_FFFF;
         if (q < -66'sd2147483648) return 32'h8000_0000;
         return q[31:0];
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfvg_pkg::BE_IDLE; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; ov_ff <= ov_in;
      end
      rad_ff <= rad_in; n_ff <= n_in; i_ff <= i_in; num_ff <= num_in;
      ang_ff <= ang_in; x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; k_ff <= k_in;
      flip_ff <= flip_in; px_ff <= px_in; py_ff <= py_in;
      ox_ff <= ox_in; oy_ff <= oy_in; onum_ff <= onum_in; of_ff <= of_in;
      os_ff <= os_in; ot_ff <= ot_in; otv_ff <= otv_in; olast_ff <= olast_in;
   end

   always_comb begin
      // doubled remainder against n, which is held above 32 zero bits
      diff = {1'b0, num_ff, 1'b0} - {2'b00, n_ff, 32'd0};
      at = cfvg_pkg::atan_turn(k_ff);
      rx = x_ff >>> k_ff;
      ry = y_ff >>> k_ff;
   end

   always_comb begin
      state_in = state_ff; rad_in = rad_ff; n_in = n_ff; i_in = i_ff;
      num_in = num_ff; ang_in = ang_ff; x_in = x_ff; y_in = y_ff; z_in = z_ff;
      k_in = k_ff; flip_in = flip_ff; px_in = px_ff; py_in = py_ff;
      ov_in = ov_ff; ox_in = ox_ff; oy_in = oy_ff; onum_in = onum_ff;
      of_in = of_ff; os_in = os_ff; ot_in = ot_ff; otv_in = otv_ff;
      olast_in = olast_ff; pop = 1'b0;
      if (ov_ff && rsp.ready) ov_in = 1'b0;
      unique case (state_ff)
         cfvg_pkg::BE_IDLE: begin
            if (!empty) begin
               pop = 1'b1;
               rad_in = job.radius; n_in = job.seg_count; i_in = '0;
               num_in = '0; ang_in = '0; k_in = '0;
               state_in = cfvg_pkg::BE_ANGLE;
            end
         end
         cfvg_pkg::BE_ANGLE: begin
            // restoring division of i*2^32 by n, one quotient bit a cycle
            if (!diff[39]) num_in = diff[37:0];
            else num_in = {num_ff[36:0], 1'b0};
            ang_in = {ang_ff[30:0], ~diff[39]};
            k_in = k_ff + 5'd1;
            if (k_ff == 5'd31) begin
               flip_in = ang_in[31] ^ ang_in[30];
               z_in = flip_in ? {1'b0, ang_in[31:0] - 32'h8000_0000} :
                                {ang_in[31], ang_in};
               z_in = {z_in[31], z_in[31:0]};
               x_in = cfvg_pkg::CORDIC_START; y_in = '0; k_in = '0;
               state_in = cfvg_pkg::BE_CORDIC;
            end
         end
         cfvg_pkg::BE_CORDIC: begin
            if (!z_ff[32]) begin
               x_in = x_ff - 34'(ry); y_in = y_ff + 34'(rx);
               z_in = z_ff - {1'b0, at};
            end else begin
               x_in = x_ff + 34'(ry); y_in = y_ff - 34'(rx);
               z_in = z_ff + {1'b0, at};
            end
            k_in = k_ff + 5'd1;
            if (k_ff == 5'd31) state_in = cfvg_pkg::BE_MUL;
         end
         cfvg_pkg::BE_MUL: begin
            px_in = $signed({34'd0, rad_ff}) * 66'(flip_ff ? -x_ff : x_ff);
            py_in = $signed({34'd0, rad_ff}) * 66'(flip_ff ? -y_ff : y_ff);
            state_in = cfvg_pkg::BE_OUT;
         end
         cfvg_pkg::BE_OUT: begin
            if (!ov_ff || rsp.ready) begin
               ov_in = 1'b1;
               ox_in = sat(px_ff); oy_in = sat(py_ff); onum_in = i_ff;
               otv_in = i_ff != n_ff; olast_in = 1'b0;
               of_in = otv_in ? i_ff : '0;
               os_in = otv_in ? i_ff + 6'd1 : '0;
               ot_in = otv_in ? n_ff + 6'd1 : '0;
               if (i_ff == n_ff) state_in = cfvg_pkg::BE_CENTRE;
               else begin
                  i_in = i_ff + 6'd1;
                  // closing vertex is a full turn, the same angle as vertex 0
                  num_in = {(i_in == n_ff) ? 6'd0 : i_in, 32'd0};
                  ang_in = '0; k_in = '0;
                  state_in = cfvg_pkg::BE_ANGLE;
               end
            end
         end
         cfvg_pkg::BE_CENTRE: begin
            if (!ov_ff || rsp.ready) begin
               ov_in = 1'b1; ox_in = '0; oy_in = '0; onum_in = n_ff + 6'd1;
               otv_in = 1'b0; of_in = '0; os_in = '0; ot_in = '0; olast_in = 1'b1;
               state_in = cfvg_pkg::BE_IDLE;
            end
         end
         default: state_in = cfvg_pkg::BE_IDLE;
      endcase
   end

   assign rsp.valid = ov_ff;
   assign rsp.vertex_x = ox_ff;
   assign rsp.vertex_y = oy_ff;
   assign rsp.vertex_number = onum_ff;
   assign rsp.tri_valid = otv_ff;
   assign rsp.tri_first = of_ff;
   assign rsp.tri_second = os_ff;
   assign rsp.tri_third = ot_ff;
   assign rsp.last = olast_ff;
endmodule

[rtl/circle_fan_vertex_generator_unit.sv]
// circle_fan_vertex_generator_unit: top level of the circle fan generator
// uses cfvg_pkg, cfvg_if, cfvg_front, cfvg_queue, cfvg_back
//
// usage: a request word on req carries centre and edge points (Q16.16).
// the front part takes it, squares the differences and takes the square
// root, then places the radius and segment count in a two-entry queue;
// it takes no new request until the previous one is in the queue.
// the back part emits segment_count+1 rim vertices and a final centre
// vertex marked last on rsp.
// each rim vertex passes in turn through the angle division, 32 cordic
// steps, a multiply and the output register; the back part starts the
// next vertex only once the output register has taken the previous one.
// the next request's root overlaps the previous request's vertices.
// csr writes segment_count; ready is always high, write only when idle.
// reset clears all control and sets segment_count to 32.
// a stalled rsp holds its word; the back part waits, the front fills the queue.
module circle_fan_vertex_generator_unit (
   input logic        clock,
   input logic        reset,
   cfvg_req_if.sink   req,
   cfvg_rsp_if.source rsp,
   cfvg_csr_if.sink   csr
);
   logic [5:0] seg_ff;
   logic push, full, pop, empty;
   cfvg_pkg::job_type fj, bj;

   always_ff @(posedge clock) begin
      if (reset) seg_ff <= cfvg_pkg::SEG_RESET;
      else if (csr.valid) seg_ff <= (csr.data > cfvg_pkg::MAX_SEGMENTS) ?
                                    cfvg_pkg::MAX_SEGMENTS : csr.data;
   end
   assign csr.ready = 1'b1;

   cfvg_front u_front (
      .clock, .reset, .req_valid(req.valid), .req_ready(req.ready),
      .cx(req.center_x), .cy(req.center_y), .cz(req.center_z),
      .ex(req.edge_x), .ey(req.edge_y), .ez(req.edge_z),
      .seg_count(seg_ff), .push, .full, .job(fj)
   );
   cfvg_queue u_queue (
      .clock, .reset, .push, .push_job(fj), .full, .pop, .empty, .pop_job(bj)
   );
   cfvg_back u_back (
      .clock, .reset, .empty, .job(bj), .pop, .rsp
   );
endmodule

[tb/circle_fan_vertex_generator_unit_tb.sv]
// circle_fan_vertex_generator_unit_tb: randomised request/response test of the circle fan
// generator with its own fixed-point radius, cordic and fan predictor
// depends on cfvg_pkg, cfvg_if and circle_fan_vertex_generator_unit
`timescale 1ns / 1ps

module circle_fan_vertex_generator_unit_tb;
   localparam int SEG_LIMIT = 62;
   localparam int QUIET_LIMIT = 20000;

   typedef struct {
      logic        is_cfg;
      logic [5:0]  seg;
      logic [31:0] ctr[3];
      logic [31:0] rim_pt[3];
   } stim_word_type;

   typedef struct {
      logic [31:0] vx, vy;
      logic [5:0]  num, t1, t2, t3;
      logic        tv, lst;
   } vertex_word_type;

   logic clock, reset;
   cfvg_req_if req_ch();
   cfvg_rsp_if rsp_ch();
   cfvg_csr_if csr_ch();

   circle_fan_vertex_generator_unit u_dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch), .csr(csr_ch)
   );

   stim_word_type   pending_q[$];
   vertex_word_type vertex_q[$];
   stim_word_type   cur;
   logic [5:0]      seg_shadow;
   int              err_count, gap, settle, hold, req_done, quiet;
   logic            hold_used;

   localparam longint ATAN_TURN[32] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1, 1, 0
   };

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic [31:0] scale_axis(longint r, longint t);
      longint p;
      p = (r * t + (64'sd1 <<< 29)) >>> 30;
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      return p[31:0];
   endfunction

   // expected vertices of one circle at the current segment count
   task automatic predict_circle(input stim_word_type w);
      longint unsigned n, sum, m, radius, i;
      longint d, x, y, z, dx, dy;
      logic [31:0] ang, a;
      logic flip, big;
      vertex_word_type v;
      n = 64'(seg_shadow);
      if (n < 1) n = 1;
      if (n > SEG_LIMIT) n = SEG_LIMIT;
      sum = 0;
      big = 1'b0;
      for (int j = 0; j < 3; j++) begin
         d = longint'(signed'(w.rim_pt[j])) - longint'(signed'(w.ctr[j]));
         m = d < 0 ? -d : d;
         if (m > 64'h7FFF_FFFF) big = 1'b1;
         else sum += m * m;
      end
      radius = big ? 64'h7FFF_FFFF : floor_root(sum);
      if (radius > 64'h7FFF_FFFF) radius = 64'h7FFF_FFFF;
      for (i = 0; i <= n; i++) begin
         ang = 32'((i << 32) / n);
         flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
         a = flip ? ang - 32'h8000_0000 : ang;
         z = longint'(signed'(a));
         x = 652032874;
         y = 0;
         for (int k = 0; k < 32; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
               x -= dx; y += dy; z -= ATAN_TURN[k];
            end else begin
               x += dx; y -= dy; z += ATAN_TURN[k];
            end
         end
         if (flip) begin
            x = -x; y = -y;
         end
         v.vx = scale_axis(longint'(radius), x);
         v.vy = scale_axis(longint'(radius), y);
         v.num = i[5:0];
         v.tv = (i < n);
         v.t1 = v.tv ? i[5:0] : 6'd0;
         v.t2 = v.tv ? 6'(i + 1) : 6'd0;
         v.t3 = v.tv ? 6'(n + 1) : 6'd0;
         v.lst = 1'b0;
         vertex_q = {vertex_q, v};
      end
      v = '{vx: 0, vy: 0, num: 6'(n + 1), tv: 0, t1: 0, t2: 0, t3: 0, lst: 1'b1};
      vertex_q = {vertex_q, v};
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      err_count++;
   endtask

   task automatic add_circle(input logic [31:0] cx, cy, cz, ex, ey, ez);
      stim_word_type w;
      w.is_cfg = 1'b0;
      w.seg = 6'd0;
      w.ctr = '{cx, cy, cz};
      w.rim_pt = '{ex, ey, ez};
      pending_q = {pending_q, w};
   endtask

   task automatic add_segments(input logic [5:0] s);
      stim_word_type w;
      w.is_cfg = 1'b1;
      w.seg = s;
      w.ctr = '{0, 0, 0};
      w.rim_pt = '{0, 0, 0};
      pending_q = {pending_q, w};
   endtask

   // mostly modest radii, some full-range, huge and degenerate words
   task automatic add_random_circle();
      logic [31:0] c[3], e[3];
      int kind;
      kind = $urandom_range(0, 9);
      for (int j = 0; j < 3; j++) begin
         c[j] = $urandom;
         case (kind)
            0, 1: e[j] = $urandom;
            2: e[j] = c[j] ^ 32'h8000_0000;
            3: e[j] = ($urandom_range(0, 1) != 0) ? c[j] : c[j] + $urandom_range(0, 255);
            default: e[j] = c[j] + 32'(signed'($urandom_range(0, 2097152)) - 1048576);
         endcase
      end
      add_circle(c[0], c[1], c[2], e[0], e[1], e[2]);
   endtask

   initial begin
      int phase_seg[9] = '{1, 0, 2, 62, 3, 63, 5, 7, 32};
      int phase_len[9] = '{90, 60, 90, 3, 70, 2, 60, 40, 6};
      reset = 1'b1;
      req_ch.valid = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.data = 6'd0;
      {req_ch.center_x, req_ch.center_y, req_ch.center_z} = '0;
      {req_ch.edge_x, req_ch.edge_y, req_ch.edge_z} = '0;
      rsp_ch.ready = 1'b0;
      err_count = 0; gap = 0; settle = 0; hold = 0; req_done = 0; quiet = 0;
      hold_used = 1'b0;
      seg_shadow = cfvg_pkg::SEG_RESET;

      // directed words at the reset segment count, then at segment counts 1, 63 and 0
      add_circle(0, 0, 0, 0, 0, 0);
      add_circle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_circle(0, 0, 0, 32'h7FFF_FFFF, 0, 0);
      add_circle(0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_circle(32'h0001_0000, 32'h0002_0000, 0, 0, 0, 32'hFFFF_0000);
      add_circle(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'hFFFF_FFFF, 0);
      add_segments(6'd1);
      add_circle(0, 0, 0, 32'h0001_0000, 0, 0);
      add_circle(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0);
      add_segments(6'd63);
      add_circle(0, 0, 0, 0, 32'h0010_0000, 0);
      add_segments(6'd0);
      add_circle(5, 5, 5, 0, 0, 0);
      for (int p = 0; p < 9; p++) begin
         add_segments(6'(phase_seg[p]));
         for (int k = 0; k < phase_len[p]; k++) add_random_circle();
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait (pending_q.size() == 0 && !req_ch.valid && !csr_ch.valid && vertex_q.size() == 0);
      repeat (300) @(posedge clock);
      if (err_count == 0 && vertex_q.size() == 0) begin
         $display("circle_fan_vertex_generator_unit_tb: done, clean");
      end else begin
         $display("circle_fan_vertex_generator_unit_tb: done, errors");
      end
      $finish;
   end

   // request and csr driver
   always @(posedge clock) begin
      logic nxt_req, nxt_csr, idling;
      nxt_req = req_ch.valid;
      nxt_csr = csr_ch.valid;
      idling = (req_done < 380);
      if (reset) begin
         nxt_req = 1'b0;
         nxt_csr = 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_circle(cur);
            req_done++;
            nxt_req = 1'b0;
         end
         if (csr_ch.valid && csr_ch.ready) begin
            seg_shadow = csr_ch.data;
            nxt_csr = 1'b0;
         end
         settle = (vertex_q.size() == 0 && !nxt_req) ? settle + 1 : 0;
         if (!nxt_req && !nxt_csr) begin
            if (gap > 0) begin
               gap--;
            end else if (pending_q.size() > 0) begin
               if (pending_q[0].is_cfg) begin
                  // segment count only changes once the block has drained
                  if (settle >= 8) begin
                     cur = pending_q.pop_front();
                     csr_ch.data <= cur.seg;
                     nxt_csr = 1'b1;
                  end
               end else begin
                  cur = pending_q.pop_front();
                  req_ch.center_x <= cur.ctr[0];
                  req_ch.center_y <= cur.ctr[1];
                  req_ch.center_z <= cur.ctr[2];
                  req_ch.edge_x <= cur.rim_pt[0];
                  req_ch.edge_y <= cur.rim_pt[1];
                  req_ch.edge_z <= cur.rim_pt[2];
                  nxt_req = 1'b1;
                  if (idling && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
               end
            end
         end
      end
      req_ch.valid <= nxt_req;
      csr_ch.valid <= nxt_csr;
   end

   // vertex receiver: random stalls plus one long hold-off to fill the queue
   always @(posedge clock) begin
      logic nxt_rdy;
      nxt_rdy = 1'b1;
      if (!reset) begin
         if (hold > 0) begin
            hold--;
            nxt_rdy = (hold == 0);
         end else if (!hold_used && req_done == 30) begin
            hold_used = 1'b1;
            hold = 400;
            nxt_rdy = 1'b0;
         end else if (req_done < 380 && $urandom_range(0, 15) == 0) begin
            hold = $urandom_range(1, 9);
            nxt_rdy = 1'b0;
         end
      end
      rsp_ch.ready <= nxt_rdy;
   end

   // vertex checker
   always @(posedge clock) begin
      vertex_word_type w;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (vertex_q.size() == 0) begin
            report_mismatch("unexpected vertex_number", 32'(rsp_ch.vertex_number), 32'd0);
         end else begin
            w = vertex_q.pop_front();
            if (rsp_ch.vertex_x !== w.vx) report_mismatch("vertex_x", rsp_ch.vertex_x, w.vx);
            if (rsp_ch.vertex_y !== w.vy) report_mismatch("vertex_y", rsp_ch.vertex_y, w.vy);
            if (rsp_ch.vertex_number !== w.num)
               report_mismatch("vertex_number", 32'(rsp_ch.vertex_number), 32'(w.num));
            if (rsp_ch.tri_valid !== w.tv)
               report_mismatch("tri_valid", 32'(rsp_ch.tri_valid), 32'(w.tv));
            if (rsp_ch.tri_first !== w.t1)
               report_mismatch("tri_first", 32'(rsp_ch.tri_first), 32'(w.t1));
            if (rsp_ch.tri_second !== w.t2)
               report_mismatch("tri_second", 32'(rsp_ch.tri_second), 32'(w.t2));
            if (rsp_ch.tri_third !== w.t3)
               report_mismatch("tri_third", 32'(rsp_ch.tri_third), 32'(w.t3));
            if (rsp_ch.last !== w.lst) report_mismatch("last", 32'(rsp_ch.last), 32'(w.lst));
         end
      end
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("circle_fan_vertex_generator_unit_tb: done, errors");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end
endmodule

[circle_fan_vertex_generator_unit.f]
rtl/cfvg_pkg.sv
rtl/cfvg_if.sv
rtl/cfvg_front.sv
rtl/cfvg_queue.sv
rtl/cfvg_back.sv
rtl/circle_fan_vertex_generator_unit.sv
tb/circle_fan_vertex_generator_unit_tb.sv
